/* design/mmm_pkg.sv */
// shared constants and types for the modular matrix multiply core
// no dependencies
`default_nettype none
package mmm_pkg;
   localparam int MAX_DIM    = 8;
   localparam int ELEM_WIDTH = 16;
   localparam int IDX_W      = $clog2(MAX_DIM);
   localparam int ADDR_W     = 2 * IDX_W;
   localparam int DIM_W      = 4;
   localparam int MOD_W      = 16;
   localparam int PROD_W     = 2 * ELEM_WIDTH;

   localparam logic [1:0] CMD_LOAD_A  = 2'd0;
   localparam logic [1:0] CMD_LOAD_B  = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   localparam logic [1:0] REG_MODULUS = 2'd0;
   localparam logic [1:0] REG_ROWS    = 2'd1;
   localparam logic [1:0] REG_INNER   = 2'd2;
   localparam logic [1:0] REG_COLS    = 2'd3;

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      clamp_dim = (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
   endfunction
endpackage
`default_nettype wire

/* design/mmm_reduce.sv */
// bit-serial signed remainder unit: residue of a 32-bit signed product mod q
// depends on mmm_pkg
`default_nettype none
module mmm_reduce
   import mmm_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [PROD_W-1:0] prod,
   input  wire logic [MOD_W-1:0]        modulus,
   output logic                         done,
   output logic [MOD_W-1:0]             residue
);
   localparam int CNT_W = $clog2(PROD_W + 1);

   logic [PROD_W-1:0] mag_ff, mag_in;
   logic [MOD_W:0]    rem_ff, rem_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [MOD_W+1:0]  shifted;
   logic [MOD_W+1:0]  diff;
   logic [MOD_W:0]    fixed;

   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, mag_ff[PROD_W-1]};
      diff    = shifted - {2'b00, modulus};
      if (start) begin
         neg_in  = prod[PROD_W-1];
         mag_in  = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
         rem_in  = '0;
         cnt_in  = CNT_W'(PROD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         mag_in = {mag_ff[PROD_W-2:0], 1'b0};
         if (!diff[MOD_W+1]) rem_in = diff[MOD_W:0];
         else rem_in = shifted[MOD_W:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign fixed   = (neg_ff && rem_ff != '0) ? ({1'b0, modulus} - rem_ff) : rem_ff;
   assign residue = fixed[MOD_W-1:0];
   assign done    = done_ff;
endmodule
`default_nettype wire

/* design/modular_matrix_multiply_core.sv */
// modular matrix multiply core: A and B element stores, sequencer, mod-q accumulate
// depends on mmm_pkg and mmm_reduce
//
// usage:
//   req_ channel carries one word per item: cmd 0 loads A[row][col], cmd 1 loads
//   B[row][col], cmd 2 computes A*B mod q and emits rows_a*cols_b words on rsp_
//   in row-major order, rsp_last marking the final one. cmd 3 is dropped.
//   a load leaves the sequencer idle; the next item is accepted the cycle after.
//   in a compute each term passes through the store read, multiply and start
//   states, then through a 32-step bit-serial remainder unit and its result
//   register; the remainder unit sets the rate.
//   results pass through one output register; when the receiver stalls the
//   sequencer waits with the next entry until that register frees.
//   csr_ port: modulus at 0x0, rows_a 0x4, inner_dim 0x8, cols_b 0xc; write
//   only while idle. reset restores modulus 2 and dimensions 1; the element
//   stores are not cleared and must be loaded before use.
`default_nettype none
module modular_matrix_multiply_core
   import mmm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [2:0]  req_row,
   input  wire logic [2:0]  req_col,
   input  wire logic signed [15:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_out_row,
   output logic [2:0]       rsp_out_col,
   output logic [15:0]      rsp_residue,
   output logic             rsp_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_RED   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;
   localparam logic [2:0] ST_START = 3'd5;

   logic [MOD_W-1:0] modulus_ff;
   logic [DIM_W-1:0] rows_ff, inner_ff, cols_ff;
   logic [1:0]       reg_sel;

   elem_type         mem_a [MAX_DIM*MAX_DIM];
   elem_type         mem_b [MAX_DIM*MAX_DIM];
   elem_type         rd_a_ff, rd_b_ff;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [MOD_W-1:0] sum_ff, sum_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic             red_start, red_done;
   logic [MOD_W-1:0] red_res;
   logic [MOD_W:0]   acc;
   logic [DIM_W-1:0] n_dim, m_dim, p_dim;
   logic             last_i, last_j, last_k, q_ok;

   logic             out_valid_ff;
   logic [2:0]       out_row_ff, out_col_ff;
   logic [15:0]      out_res_ff;
   logic             out_last_ff;
   logic             out_free;
   logic             load_ok;
   logic             rd_en;

   assign reg_sel    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (reg_sel)
         REG_MODULUS: csr_prdata = {16'd0, modulus_ff};
         REG_ROWS:    csr_prdata = {28'd0, rows_ff};
         REG_INNER:   csr_prdata = {28'd0, inner_ff};
         REG_COLS:    csr_prdata = {28'd0, cols_ff};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= 16'd2;
         rows_ff    <= 4'd1;
         inner_ff   <= 4'd1;
         cols_ff    <= 4'd1;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_sel)
            REG_MODULUS: modulus_ff <= csr_pwdata[15:0];
            REG_ROWS:    rows_ff    <= csr_pwdata[3:0];
            REG_INNER:   inner_ff   <= csr_pwdata[3:0];
            REG_COLS:    cols_ff    <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   assign n_dim  = clamp_dim(rows_ff);
   assign m_dim  = clamp_dim(inner_ff);
   assign p_dim  = clamp_dim(cols_ff);
   assign q_ok   = modulus_ff >= 16'd2;
   assign last_i = DIM_W'(i_ff) == n_dim - 1'b1;
   assign last_j = DIM_W'(j_ff) == p_dim - 1'b1;
   assign last_k = DIM_W'(k_ff) == m_dim - 1'b1;

   assign req_ready = state_ff == ST_IDLE;
   assign load_ok   = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;

   // element stores
   always_ff @(posedge clock) begin
      if (load_ok && req_cmd == CMD_LOAD_A) mem_a[{req_row, req_col}] <= req_value;
      if (load_ok && req_cmd == CMD_LOAD_B) mem_b[{req_row, req_col}] <= req_value;
      if (rd_en) begin
         rd_a_ff <= mem_a[{i_ff, k_ff}];
         rd_b_ff <= mem_b[{k_ff, j_ff}];
      end
   end

   assign acc = {1'b0, sum_ff} + {1'b0, red_res};

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      sum_in    = sum_ff;
      red_start = 1'b0;
      rd_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (load_ok && req_cmd == CMD_COMPUTE && n_dim != 0 && p_dim != 0) begin
               i_in   = '0;
               j_in   = '0;
               k_in   = '0;
               sum_in = '0;
               state_in = (m_dim != 0 && q_ok) ? ST_READ : ST_EMIT;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_START;
         end
         ST_START: begin
            red_start = 1'b1;
            state_in  = ST_RED;
         end
         ST_RED: begin
            if (red_done) begin
               sum_in = (acc >= {1'b0, modulus_ff}) ?
                        MOD_W'(acc - {1'b0, modulus_ff}) : MOD_W'(acc);
               if (last_k) state_in = ST_EMIT;
               else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               k_in   = '0;
               sum_in = '0;
               if (last_j) begin
                  j_in = '0;
                  i_in = i_ff + 1'b1;
               end else j_in = j_ff + 1'b1;
               if (last_i && last_j) state_in = ST_IDLE;
               else state_in = (m_dim != 0 && q_ok) ? ST_READ : ST_EMIT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(rd_a_ff * rd_b_ff);
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      sum_ff  <= sum_in;
      if (state_ff == ST_EMIT && out_free) begin
         out_row_ff  <= i_ff;
         out_col_ff  <= j_ff;
         out_res_ff  <= sum_ff;
         out_last_ff <= last_i && last_j;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_EMIT && out_free) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   mmm_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .start   (red_start),
      .prod    (prod_ff),
      .modulus (modulus_ff),
      .done    (red_done),
      .residue (red_res)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_out_row = out_row_ff;
   assign rsp_out_col = out_col_ff;
   assign rsp_residue = out_res_ff;
   assign rsp_last    = out_last_ff;
endmodule
`default_nettype wire

/* design/mmm_checker.sv */
// port-level checks for the modular matrix multiply core
// depends on modular_matrix_multiply_core ports
`default_nettype none
module mmm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_residue,
   input wire logic        rsp_last,
   input wire logic        req_ready,
   input wire logic        csr_pready
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_residue))
      else $error("word dropped under stall");
   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready || rsp_last || $past(rsp_last))
      else $error("input taken mid burst");
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("valid after reset");
endmodule

bind modular_matrix_multiply_core mmm_checker u_mmm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_residue (rsp_residue),
   .rsp_last    (rsp_last),
   .req_ready   (req_ready),
   .csr_pready  (csr_pready)
);
`default_nettype wire
